// ===== hw/rtl/almux_pkg.sv =====
// ----------------------------------------------------------------------------
// almux_pkg
// Transaction types and action codes for the alarm multiplexer.
// ----------------------------------------------------------------------------
package almux_pkg;

    localparam logic [2:0] ACT_ACTIVATE = 3'd0;
    localparam logic [2:0] ACT_SET      = 3'd1;
    localparam logic [2:0] ACT_CANCEL   = 3'd2;
    localparam logic [2:0] ACT_STOP     = 3'd3;
    localparam logic [2:0] ACT_ALARM    = 3'd4;

    localparam logic KIND_WAKE    = 1'b0;
    localparam logic KIND_PROGRAM = 1'b1;

    localparam logic [63:0] TIME_NONE = '1;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  slot;
        logic [63:0] trigger_time;
        logic [63:0] current_time;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [3:0]  slot_out;
        logic [63:0] wake_value;
        logic [31:0] compare_value;
        logic        enable_write;
        logic        last;
    } t_out_item;

endpackage

// ===== hw/rtl/alarm_multiplexer.sv =====
// ----------------------------------------------------------------------------
// alarm_multiplexer
// Many software timer slots sharing one 32-bit hardware compare alarm.
// ----------------------------------------------------------------------------
// Takes one transaction at a time. Activate and cancel go through the execute
// state and straight back to idle; set trigger and stop may also wait there
// for the output register. An alarm event scans the slot trigger memory
// through its single read port, one slot per cycle while no held wake waits on
// a busy output. Trigger times live in a synchronous memory; per-slot armed
// and active bits are flops that reset clears, so no clearing pass is needed
// after reset. A wake is held one step before it goes out so that the final
// result can carry last.
module alarm_multiplexer #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  almux_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output almux_pkg::t_out_item o_out_data
);
    import almux_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]           r_state, n_state;
    t_in_item             r_item;
    logic [NUM_SLOTS-1:0] r_active, n_active;
    logic [NUM_SLOTS-1:0] r_trig_vld, n_trig_vld;
    logic [63:0]          r_closest, n_closest;
    logic [SLOT_W-1:0]    r_idx, n_idx;
    logic                 r_pend_vld, n_pend_vld;
    logic [SLOT_W-1:0]    r_pend_slot, n_pend_slot;
    logic                 r_out_vld;
    t_out_item            r_out;

    // trigger memory
    logic [63:0]          r_mem [NUM_SLOTS];
    logic [63:0]          r_rdata;
    logic                 r_rd_vld;
    logic                 mem_we;
    logic                 mem_re;
    logic [SLOT_W-1:0]    mem_raddr;

    logic                 out_load;
    t_out_item            out_next;
    logic                 out_free;
    logic [SLOT_W-1:0]    item_idx;
    logic                 slot_ok;
    logic                 hit;
    logic                 earlier;
    logic                 armed;
    logic                 fire;

    assign out_free    = !r_out_vld || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign item_idx = SLOT_W'(r_item.slot);
    assign slot_ok  = (int'(r_item.slot) < NUM_SLOTS);
    assign hit      = slot_ok && r_active[item_idx];
    assign earlier  = (r_item.trigger_time < r_closest);
    // an entry holding all ones is disarmed even when written
    assign armed    = r_rd_vld && (r_rdata != TIME_NONE);
    assign fire     = armed && (r_rdata < r_item.current_time);

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_trig_vld  = r_trig_vld;
        n_closest   = r_closest;
        n_idx       = r_idx;
        n_pend_vld  = r_pend_vld;
        n_pend_slot = r_pend_slot;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = SLOT_W'(r_idx + 1'b1);
        out_load    = 1'b0;
        out_next    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_item.action)
                    ACT_ACTIVATE: begin
                        if (slot_ok) begin
                            n_active[item_idx]   = 1'b1;
                            n_trig_vld[item_idx] = 1'b0;
                        end
                        n_state = S_IDLE;
                    end
                    ACT_SET: begin
                        if (!hit) begin
                            n_state = S_IDLE;
                        end else if (!earlier || out_free) begin
                            mem_we               = 1'b1;
                            n_trig_vld[item_idx] = 1'b1;
                            if (earlier) begin
                                n_closest              = r_item.trigger_time;
                                out_load               = 1'b1;
                                out_next.kind          = KIND_PROGRAM;
                                out_next.compare_value = r_item.trigger_time[31:0];
                                out_next.enable_write  = (r_closest == TIME_NONE);
                                out_next.last          = 1'b1;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    ACT_CANCEL: begin
                        if (hit) begin
                            n_trig_vld[item_idx] = 1'b0;
                        end
                        n_state = S_IDLE;
                    end
                    ACT_STOP: begin
                        if (!hit) begin
                            n_state = S_IDLE;
                        end else if (out_free) begin
                            n_trig_vld[item_idx] = 1'b0;
                            n_active[item_idx]   = 1'b0;
                            out_load             = 1'b1;
                            out_next.kind        = KIND_WAKE;
                            out_next.slot_out    = r_item.slot;
                            out_next.last        = 1'b1;
                            n_state              = S_IDLE;
                        end
                    end
                    ACT_ALARM: begin
                        n_closest  = TIME_NONE;
                        n_pend_vld = 1'b0;
                        mem_re     = 1'b1;
                        mem_raddr  = '0;
                        n_idx      = '0;
                        n_state    = S_SCAN;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                // stall only when a held wake must go out and the output is busy
                if (!(fire && r_pend_vld && !out_free)) begin
                    if (fire) begin
                        n_trig_vld[r_idx] = 1'b0;
                        if (r_pend_vld) begin
                            out_load            = 1'b1;
                            out_next.kind       = KIND_WAKE;
                            out_next.slot_out   = 4'(r_pend_slot);
                            out_next.wake_value = r_item.current_time;
                        end
                        n_pend_vld  = 1'b1;
                        n_pend_slot = r_idx;
                    end else if (armed && (r_rdata < r_closest)) begin
                        n_closest = r_rdata;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_FIN;
                    end else begin
                        mem_re = 1'b1;
                        n_idx  = SLOT_W'(r_idx + 1'b1);
                    end
                end
            end
            S_FIN: begin
                if (r_pend_vld) begin
                    if (out_free) begin
                        out_load            = 1'b1;
                        out_next.kind       = KIND_WAKE;
                        out_next.slot_out   = 4'(r_pend_slot);
                        out_next.wake_value = r_item.current_time;
                        out_next.last       = (r_closest == TIME_NONE);
                        n_pend_vld          = 1'b0;
                        if (r_closest == TIME_NONE) begin
                            n_state = S_IDLE;
                        end
                    end
                end else if (r_closest == TIME_NONE) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    out_load               = 1'b1;
                    out_next.kind          = KIND_PROGRAM;
                    out_next.compare_value = r_closest[31:0];
                    out_next.enable_write  = 1'b1;
                    out_next.last          = 1'b1;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_active   <= '0;
            r_trig_vld <= '0;
            r_closest  <= TIME_NONE;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_active   <= n_active;
            r_trig_vld <= n_trig_vld;
            r_closest  <= n_closest;
            r_pend_vld <= n_pend_vld;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_data;
        end
        if (out_load) begin
            r_out <= out_next;
        end
        r_idx       <= n_idx;
        r_pend_slot <= n_pend_slot;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[item_idx] <= r_item.trigger_time;
        end
        if (mem_re) begin
            r_rdata  <= r_mem[mem_raddr];
            r_rd_vld <= r_trig_vld[mem_raddr];
        end
    end

endmodule

// ===== sim/tb_alarm_multiplexer.sv =====
// ----------------------------------------------------------------------------
// tb_alarm_multiplexer
// Self-checking testbench for the timer slot / compare alarm multiplexer.
// ----------------------------------------------------------------------------
// Drives activate, set, cancel, stop and alarm transactions over the input
// channel, tracks the slot table and closest time in a scoreboard, and checks
// every wake and compare program that comes back, field by field and in order.
// A directed opening covers the corner cases, then random timer traffic runs
// around a moving wall time under three idling patterns and one long output
// hold-off.
// ----------------------------------------------------------------------------
module tb_alarm_multiplexer;
    timeunit 1ns;
    timeprecision 1ps;

    import almux_pkg::*;

    localparam int NUM_SLOTS     = 16;
    localparam int RANDOM_ITEMS  = 108;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 40;

    class alarm_scoreboard;
        logic [63:0] slot_time [NUM_SLOTS];
        bit          slot_live [NUM_SLOTS];
        logic [63:0] nearest_time;
        t_out_item   pending_results [$];
        int          mismatch_count;
        int          results_checked;
        int          wakes_expected;
        int          programs_expected;
        int          longest_burst;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_time[i] = TIME_NONE;
                slot_live[i] = 1'b0;
            end
            nearest_time = TIME_NONE;
        endfunction

        function void queue_result(logic kind, logic [3:0] slot, logic [63:0] wake,
                                   logic [31:0] compare, logic enable);
            t_out_item r;
            r.kind          = kind;
            r.slot_out      = slot;
            r.wake_value    = wake;
            r.compare_value = compare;
            r.enable_write  = enable;
            r.last          = 1'b0;
            pending_results.push_back(r);
            if (kind == KIND_WAKE) begin
                wakes_expected++;
            end else begin
                programs_expected++;
            end
        endfunction

        // returns 0 when the block should ignore the transaction entirely
        function bit note_action(t_in_item item);
            int        before_count;
            int        burst;
            bit        taken;
            t_out_item tail;
            before_count = pending_results.size();
            taken = 1'b1;
            case (item.action)
                ACT_ACTIVATE: begin
                    if (int'(item.slot) >= NUM_SLOTS) begin
                        taken = 1'b0;
                    end else begin
                        slot_live[item.slot] = 1'b1;
                        slot_time[item.slot] = TIME_NONE;
                    end
                end
                ACT_SET, ACT_CANCEL, ACT_STOP: begin
                    if (int'(item.slot) >= NUM_SLOTS || !slot_live[item.slot]) begin
                        taken = 1'b0;
                    end else if (item.action == ACT_SET) begin
                        slot_time[item.slot] = item.trigger_time;
                        if (item.trigger_time < nearest_time) begin
                            queue_result(KIND_PROGRAM, '0, '0, item.trigger_time[31:0],
                                         nearest_time == TIME_NONE);
                            nearest_time = item.trigger_time;
                        end
                    end else if (item.action == ACT_CANCEL) begin
                        slot_time[item.slot] = TIME_NONE;
                    end else begin
                        slot_time[item.slot] = TIME_NONE;
                        slot_live[item.slot] = 1'b0;
                        queue_result(KIND_WAKE, item.slot, '0, '0, 1'b0);
                    end
                end
                ACT_ALARM: begin
                    nearest_time = TIME_NONE;
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (slot_time[i] != TIME_NONE) begin
                            if (slot_time[i] < item.current_time) begin
                                slot_time[i] = TIME_NONE;
                                queue_result(KIND_WAKE, 4'(i), item.current_time, '0, 1'b0);
                            end else if (slot_time[i] < nearest_time) begin
                                nearest_time = slot_time[i];
                            end
                        end
                    end
                    if (nearest_time != TIME_NONE) begin
                        queue_result(KIND_PROGRAM, '0, '0, nearest_time[31:0], 1'b1);
                    end
                end
                default: taken = 1'b0;
            endcase
            burst = pending_results.size() - before_count;
            if (burst > 0) begin
                tail = pending_results.pop_back();
                tail.last = 1'b1;
                pending_results.push_back(tail);
            end
            if (burst > longest_burst) begin
                longest_burst = burst;
            end
            return taken;
        endfunction

        task report_mismatch(string msg);
            if (mismatch_count < MAX_REPORTS) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
            mismatch_count++;
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("result %0d %s got %h expected %h",
                                          results_checked, name, got, want));
            end
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing outstanding: %h", got));
                return;
            end
            want = pending_results.pop_front();
            compare_field("kind", 64'(got.kind), 64'(want.kind));
            compare_field("slot_out", 64'(got.slot_out), 64'(want.slot_out));
            compare_field("wake_value", got.wake_value, want.wake_value);
            compare_field("compare_value", 64'(got.compare_value), 64'(want.compare_value));
            compare_field("enable_write", 64'(got.enable_write), 64'(want.enable_write));
            compare_field("last", 64'(got.last), 64'(want.last));
            results_checked++;
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    alarm_scoreboard sb;
    int send_idle_pct = 23;
    int recv_idle_pct = 83;
    bit hold_request = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int items_sent = 0;
    int items_taken = 0;

    alarm_multiplexer #(
        .NUM_SLOTS(NUM_SLOTS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // output side: check accepted results, then decide next cycle's ready
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_result(out_data);
        end
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_done) begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[%0t] no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_in_item make_item(logic [2:0] action, logic [3:0] slot,
                                           logic [63:0] trig, logic [63:0] now);
        t_in_item item;
        item.action       = action;
        item.slot         = slot;
        item.trigger_time = trig;
        item.current_time = now;
        return item;
    endfunction

    // valid stays up across back-to-back transactions, so it is only lowered on a gap
    task automatic send_item(t_in_item item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        items_sent++;
        if (sb.note_action(item)) begin
            items_taken++;
        end
    endtask

    function automatic logic [3:0] pick_slot(bit want_live);
        logic [3:0] s;
        s = 4'($urandom_range(0, NUM_SLOTS - 1));
        if (want_live) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                if (!sb.slot_live[s]) begin
                    s = 4'((int'(s) + 1) % NUM_SLOTS);
                end
            end
        end
        return s;
    endfunction

    function automatic logic [63:0] pick_trigger(logic [63:0] base);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return base + 64'($urandom_range(1, 2000));
        end
        if (pick < 80) begin
            return base - 64'($urandom_range(0, 300));
        end
        if (pick < 94) begin
            return {$urandom, $urandom};
        end
        return TIME_NONE;
    endfunction

    initial begin : stimulus
        int          pick;
        int          random_sent;
        logic [2:0]  action;
        logic [63:0] wall;
        logic [63:0] now;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening: ignored cases, extremes, strict compare, truncation
        send_item(make_item(ACT_SET, 4'd3, 64'd100, '0));
        send_item(make_item(ACT_ALARM, 4'd0, '0, '0));
        send_item(make_item(ACT_ACTIVATE, 4'd0, '0, '0));
        send_item(make_item(ACT_ACTIVATE, 4'd15, '1, '1));
        send_item(make_item(ACT_SET, 4'd0, 64'h0000_0001_0000_0010, '0));
        send_item(make_item(ACT_SET, 4'd15, 64'd0, '0));
        send_item(make_item(ACT_SET, 4'd15, TIME_NONE, '0));
        send_item(make_item(ACT_CANCEL, 4'd0, '0, '0));
        send_item(make_item(ACT_ACTIVATE, 4'd7, '0, '0));
        send_item(make_item(ACT_SET, 4'd7, 64'hFFFF_FFFF_FFFF_FFFE, '0));
        send_item(make_item(ACT_ALARM, 4'd0, '0, '1));
        send_item(make_item(ACT_SET, 4'd0, 64'd5, '0));
        send_item(make_item(ACT_SET, 4'd15, 64'd5, '0));
        send_item(make_item(ACT_ALARM, 4'd0, '0, 64'd5));
        send_item(make_item(ACT_STOP, 4'd15, '0, '0));
        send_item(make_item(ACT_STOP, 4'd15, '0, '0));
        send_item(make_item(ACT_CANCEL, 4'd15, '0, '0));
        send_item(make_item(3'd5, 4'd15, '1, '1));
        send_item(make_item(3'd6, 4'd15, '1, '1));
        send_item(make_item(3'd7, 4'd15, '1, '1));
        send_item(make_item(ACT_ACTIVATE, 4'd0, '0, '0));
        send_item(make_item(ACT_ALARM, 4'd9, '1, 64'h8000_0000_0000_0000));

        // random timer traffic around a moving wall time
        wall = {1'b0, 31'($urandom), $urandom};
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent == RANDOM_ITEMS / 3) begin
                send_idle_pct = 83;
                recv_idle_pct = 23;
            end else if (random_sent == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_request  = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                action = ACT_ACTIVATE;
            end else if (pick < 50) begin
                action = ACT_SET;
            end else if (pick < 57) begin
                action = ACT_CANCEL;
            end else if (pick < 63) begin
                action = ACT_STOP;
            end else if (pick < 95) begin
                action = ACT_ALARM;
            end else begin
                action = 3'($urandom_range(5, 7));
            end
            if (action == ACT_ALARM) begin
                wall = wall + 64'($urandom_range(0, 600));
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    now = {$urandom, $urandom};
                end else if (pick < 7) begin
                    now = TIME_NONE;
                end else begin
                    now = wall;
                end
            end else begin
                now = {$urandom, $urandom};
            end
            send_item(make_item(action,
                                pick_slot(action != ACT_ACTIVATE && $urandom_range(0, 9) < 8),
                                pick_trigger(wall), now));
            random_sent++;
        end

        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (2 * NUM_SLOTS + 10) @(posedge clk);

        $display("covered %0d transactions, %0d acted on; %0d results checked",
                 items_sent, items_taken, sb.results_checked);
        $display("%0d slot wakes, %0d compare programs, longest burst %0d results",
                 sb.wakes_expected, sb.programs_expected, sb.longest_burst);
        if (sb.mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", sb.mismatch_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== alarm_multiplexer.f =====
hw/rtl/almux_pkg.sv
hw/rtl/alarm_multiplexer.sv
sim/tb_alarm_multiplexer.sv
